[src/mzb_pkg.sv]
// ----------------------------------------------------------------------------
// mzb_pkg
// Shared types and constants for the maze backtracker step engine.
// ----------------------------------------------------------------------------
package mzb_pkg;

  // Default grid limits
  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_ROWS = 64;

  // Request kinds
  localparam logic [1:0] KIND_INIT  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_STEP  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_WALK_MODE = 2'd0;
  localparam logic [1:0] CFG_COLS      = 2'd1;
  localparam logic [1:0] CFG_ROWS      = 2'd2;

  // Configuration reset values
  localparam logic [6:0] COLS_RESET = 7'd64;
  localparam logic [6:0] ROWS_RESET = 7'd64;

  // Directions: west is column - 1, north is row - 1
  localparam logic [1:0] DIR_WEST  = 2'd0;
  localparam logic [1:0] DIR_NORTH = 2'd1;
  localparam logic [1:0] DIR_EAST  = 2'd2;
  localparam logic [1:0] DIR_SOUTH = 2'd3;

  // Cell entry layout
  localparam int CELL_W     = 6;
  localparam int CELL_RWALL = 0;
  localparam int CELL_BWALL = 1;
  localparam int CELL_GEN   = 2;
  localparam int CELL_VIS   = 3;
  localparam int CELL_DEAD  = 4;
  localparam int CELL_TURN  = 5;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT_WR,
    S_START_RD,
    S_START_WR,
    S_TOP_RD,
    S_TOP_CAP,
    S_NB_ADDR,
    S_NB_CHK,
    S_WR_TOP,
    S_PUSH,
    S_POP,
    S_POP_RD,
    S_POP_CAP,
    S_DONE
  } mzb_state_t;

endpackage

[src/mzb_ram.sv]
// ----------------------------------------------------------------------------
// mzb_ram
// Single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module mzb_ram #(
  parameter int WIDTH = mzb_pkg::CELL_W,
  parameter int DEPTH = mzb_pkg::DEF_MAX_COLS * mzb_pkg::DEF_MAX_ROWS
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write or read, never both
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

[src/maze_backtracker_step.sv]
// ----------------------------------------------------------------------------
// maze_backtracker_step
// Depth-first maze engine: builds or solves a grid maze with a cell stack.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready: kind 0 writes one cell (walls up,
//   flags clear, turn sense), kind 1 starts a walk at a cell, kind 2 does one
//   walk step from the cell on top of the stack. Every request returns one
//   result on out_valid/out_ready with moved, dead_end and the stack top.
//   Configuration is written on cfg_valid/cfg_index/cfg_data (always ready);
//   the user must write it only while the engine is idle; it is not enforced.
// Operation:
//   One request at a time; in_ready is high only in idle. Cell store and
//   stack are single-port RAMs, one access per cycle, and the neighbour
//   address/bounds unit is shared over the four directions.
//   Init writes the cell. Start reads the cell, marks it and pushes it,
//   unless it lies outside the grid. A request of unused kind or a step on
//   an empty stack only returns a result. A step reads the top cell, reads
//   each in-bounds neighbour in turn, then ends (full stack), pushes (writing
//   the top cell first when one of its walls falls) or pops, reloading the new top.
// Reset: stack empties, mode generate, grid 64 x 64. Cell store and stack
//   contents are not cleared. A stalled result holds the following result in
//   its last cycle, and with it any further request.
// ----------------------------------------------------------------------------
module maze_backtracker_step #(
  parameter int MAX_COLS = mzb_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = mzb_pkg::DEF_MAX_ROWS
) (
  input  logic       clk,
  input  logic       rst_n,
  // request channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [5:0] in_cell_col,
  input  logic [5:0] in_cell_row,
  input  logic [1:0] in_first_dir,
  input  logic       in_turn_back,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_moved,
  output logic       out_dead_end,
  output logic [5:0] out_top_col,
  output logic [5:0] out_top_row,
  output logic       out_stack_empty,
  // configuration channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);

  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CELLS = MAX_COLS * MAX_ROWS;
  localparam int SAW   = $clog2(CELLS);
  localparam int SCW   = $clog2(CELLS + 1);
  localparam int CLW   = (CW + 1 > 7) ? CW + 1 : 7;
  localparam int RLW   = (RW + 1 > 7) ? RW + 1 : 7;
  localparam int CAW   = CW + RW;
  localparam int CDW   = mzb_pkg::CELL_W;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  mzb_pkg::mzb_state_t state_r, state_nxt;

  logic           walk_mode_r;
  logic [6:0]     cols_r;
  logic [6:0]     rows_r;

  logic [SCW-1:0] count_r, count_nxt;
  logic [CW-1:0]  top_col_r, top_col_nxt;
  logic [RW-1:0]  top_row_r, top_row_nxt;
  logic [CW-1:0]  req_col_r, req_col_nxt;
  logic [RW-1:0]  req_row_r, req_row_nxt;
  logic           req_turn_r, req_turn_nxt;
  logic [1:0]     dir_r, dir_nxt;
  logic [1:0]     try_r, try_nxt;
  logic [CDW-1:0] topcell_r, topcell_nxt;
  logic [CDW-1:0] nbcell_r, nbcell_nxt;
  logic [CW-1:0]  nb_col_r, nb_col_nxt;
  logic [RW-1:0]  nb_row_r, nb_row_nxt;
  logic           moved_r, moved_nxt;
  logic           dead_r, dead_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic           out_moved_r, out_moved_nxt;
  logic           out_dead_r, out_dead_nxt;
  logic [5:0]     out_col_r, out_col_nxt;
  logic [5:0]     out_row_r, out_row_nxt;
  logic           out_empty_r, out_empty_nxt;

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  logic           cell_en, cell_we;
  logic [CAW-1:0] cell_addr;
  logic [CDW-1:0] cell_wdata, cell_rdata;
  logic           stk_en, stk_we;
  logic [SAW-1:0] stk_addr;
  logic [CAW-1:0] stk_wdata, stk_rdata;

  mzb_ram #(.WIDTH(CDW), .DEPTH(2 ** CAW)) u_cell_ram (
    .clk   (clk),
    .en    (cell_en),
    .we    (cell_we),
    .addr  (cell_addr),
    .wdata (cell_wdata),
    .rdata (cell_rdata)
  );

  mzb_ram #(.WIDTH(CAW), .DEPTH(CELLS)) u_stack_ram (
    .clk   (clk),
    .en    (stk_en),
    .we    (stk_we),
    .addr  (stk_addr),
    .wdata (stk_wdata),
    .rdata (stk_rdata)
  );

  // --------------------------------------------------------------------------
  // Grid limits and request checks
  // --------------------------------------------------------------------------
  logic [CLW-1:0] used_cols;
  logic [RLW-1:0] used_rows;
  logic           in_store, in_grid;

  assign used_cols = (CLW'(cols_r) > CLW'(MAX_COLS)) ? CLW'(MAX_COLS) : CLW'(cols_r);
  assign used_rows = (RLW'(rows_r) > RLW'(MAX_ROWS)) ? RLW'(MAX_ROWS) : RLW'(rows_r);

  assign in_store = (CLW'(in_cell_col) < CLW'(MAX_COLS)) &&
                    (RLW'(in_cell_row) < RLW'(MAX_ROWS));
  assign in_grid  = (CLW'(in_cell_col) < used_cols) && (RLW'(in_cell_row) < used_rows);

  // --------------------------------------------------------------------------
  // Shared neighbour unit: address and bounds for the current direction
  // --------------------------------------------------------------------------
  logic [CW:0] nb_x;
  logic [RW:0] nb_y;
  logic        nb_edge_ok, nb_ok;
  logic [1:0]  dir_adv;

  always_comb begin
    nb_x       = {1'b0, top_col_r};
    nb_y       = {1'b0, top_row_r};
    nb_edge_ok = 1'b1;
    unique case (dir_r)
      mzb_pkg::DIR_WEST: begin
        nb_edge_ok = (top_col_r != '0);
        nb_x       = {1'b0, top_col_r} - (CW+1)'(1);
      end
      mzb_pkg::DIR_NORTH: begin
        nb_edge_ok = (top_row_r != '0);
        nb_y       = {1'b0, top_row_r} - (RW+1)'(1);
      end
      mzb_pkg::DIR_EAST:  nb_x = {1'b0, top_col_r} + (CW+1)'(1);
      mzb_pkg::DIR_SOUTH: nb_y = {1'b0, top_row_r} + (RW+1)'(1);
      default: nb_edge_ok = 1'b0;
    endcase
    nb_ok = nb_edge_ok && (CLW'(nb_x) < used_cols) && (RLW'(nb_y) < used_rows);
  end

  assign dir_adv = dir_r + (topcell_r[mzb_pkg::CELL_TURN] ? 2'd3 : 2'd1);

  // neighbour usable, judged on the freshly read entry
  logic nb_wall, nb_found, stack_full;

  always_comb begin
    unique case (dir_r)
      mzb_pkg::DIR_WEST:  nb_wall = cell_rdata[mzb_pkg::CELL_RWALL];
      mzb_pkg::DIR_NORTH: nb_wall = cell_rdata[mzb_pkg::CELL_BWALL];
      mzb_pkg::DIR_EAST:  nb_wall = topcell_r[mzb_pkg::CELL_RWALL];
      mzb_pkg::DIR_SOUTH: nb_wall = topcell_r[mzb_pkg::CELL_BWALL];
      default:            nb_wall = 1'b1;
    endcase
    if (!walk_mode_r) begin
      nb_found = !cell_rdata[mzb_pkg::CELL_GEN];
    end else begin
      nb_found = !nb_wall && !cell_rdata[mzb_pkg::CELL_VIS] &&
                 !cell_rdata[mzb_pkg::CELL_DEAD];
    end
  end

  assign stack_full = (count_r == SCW'(CELLS));

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mzb_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            mzb_pkg::KIND_INIT:  state_nxt = in_store ? mzb_pkg::S_INIT_WR : mzb_pkg::S_DONE;
            mzb_pkg::KIND_START: state_nxt = in_grid ? mzb_pkg::S_START_RD : mzb_pkg::S_DONE;
            mzb_pkg::KIND_STEP:  state_nxt = (count_r == '0) ? mzb_pkg::S_DONE :
                                                               mzb_pkg::S_TOP_RD;
            default:             state_nxt = mzb_pkg::S_DONE;
          endcase
        end
      end
      mzb_pkg::S_INIT_WR:  state_nxt = mzb_pkg::S_DONE;
      mzb_pkg::S_START_RD: state_nxt = mzb_pkg::S_START_WR;
      mzb_pkg::S_START_WR: state_nxt = mzb_pkg::S_DONE;
      mzb_pkg::S_TOP_RD:   state_nxt = mzb_pkg::S_TOP_CAP;
      mzb_pkg::S_TOP_CAP:  state_nxt = mzb_pkg::S_NB_ADDR;
      mzb_pkg::S_NB_ADDR: begin
        if (nb_ok) begin
          state_nxt = mzb_pkg::S_NB_CHK;
        end else if (try_r == 2'd3) begin
          state_nxt = mzb_pkg::S_POP;
        end
      end
      mzb_pkg::S_NB_CHK: begin
        if (nb_found) begin
          if (stack_full) begin
            state_nxt = mzb_pkg::S_DONE;
          end else if (!walk_mode_r && dir_r[1]) begin
            state_nxt = mzb_pkg::S_WR_TOP;
          end else begin
            state_nxt = mzb_pkg::S_PUSH;
          end
        end else if (try_r == 2'd3) begin
          state_nxt = mzb_pkg::S_POP;
        end else begin
          state_nxt = mzb_pkg::S_NB_ADDR;
        end
      end
      mzb_pkg::S_WR_TOP:  state_nxt = mzb_pkg::S_PUSH;
      mzb_pkg::S_PUSH:    state_nxt = mzb_pkg::S_DONE;
      mzb_pkg::S_POP:     state_nxt = (count_r == SCW'(1)) ? mzb_pkg::S_DONE :
                                                             mzb_pkg::S_POP_RD;
      mzb_pkg::S_POP_RD:  state_nxt = mzb_pkg::S_POP_CAP;
      mzb_pkg::S_POP_CAP: state_nxt = mzb_pkg::S_DONE;
      mzb_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = mzb_pkg::S_IDLE;
        end
      end
      default: state_nxt = mzb_pkg::S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and memory control
  // --------------------------------------------------------------------------
  logic [CDW-1:0] cell_v;

  always_comb begin
    count_nxt     = count_r;
    top_col_nxt   = top_col_r;
    top_row_nxt   = top_row_r;
    req_col_nxt   = req_col_r;
    req_row_nxt   = req_row_r;
    req_turn_nxt  = req_turn_r;
    dir_nxt       = dir_r;
    try_nxt       = try_r;
    topcell_nxt   = topcell_r;
    nbcell_nxt    = nbcell_r;
    nb_col_nxt    = nb_col_r;
    nb_row_nxt    = nb_row_r;
    moved_nxt     = moved_r;
    dead_nxt      = dead_r;
    out_valid_nxt = out_valid_r;
    out_moved_nxt = out_moved_r;
    out_dead_nxt  = out_dead_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_empty_nxt = out_empty_r;
    cell_en       = 1'b0;
    cell_we       = 1'b0;
    cell_addr     = {req_row_r, req_col_r};
    cell_wdata    = '0;
    stk_en        = 1'b0;
    stk_we        = 1'b0;
    stk_addr      = '0;
    stk_wdata     = {req_row_r, req_col_r};
    cell_v        = '0;

    // result register drains independently
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      mzb_pkg::S_IDLE: begin
        if (in_valid) begin
          req_col_nxt  = CW'(in_cell_col);
          req_row_nxt  = RW'(in_cell_row);
          req_turn_nxt = in_turn_back;
          dir_nxt      = in_first_dir;
          try_nxt      = '0;
          moved_nxt    = 1'b0;
          dead_nxt     = 1'b0;
        end
      end
      mzb_pkg::S_INIT_WR: begin
        cell_v                      = '0;
        cell_v[mzb_pkg::CELL_RWALL] = 1'b1;
        cell_v[mzb_pkg::CELL_BWALL] = 1'b1;
        cell_v[mzb_pkg::CELL_TURN]  = req_turn_r;
        cell_en                     = 1'b1;
        cell_we                     = 1'b1;
        cell_wdata                  = cell_v;
      end
      mzb_pkg::S_START_RD: begin
        cell_en = 1'b1;
      end
      mzb_pkg::S_START_WR: begin
        cell_v = cell_rdata;
        if (walk_mode_r) begin
          cell_v[mzb_pkg::CELL_VIS] = 1'b1;
        end else begin
          cell_v[mzb_pkg::CELL_GEN] = 1'b1;
        end
        cell_en     = 1'b1;
        cell_we     = 1'b1;
        cell_wdata  = cell_v;
        stk_en      = 1'b1;
        stk_we      = 1'b1;
        count_nxt   = SCW'(1);
        top_col_nxt = req_col_r;
        top_row_nxt = req_row_r;
      end
      mzb_pkg::S_TOP_RD: begin
        cell_en   = 1'b1;
        cell_addr = {top_row_r, top_col_r};
      end
      mzb_pkg::S_TOP_CAP: begin
        topcell_nxt = cell_rdata;
      end
      mzb_pkg::S_NB_ADDR: begin
        if (nb_ok) begin
          cell_en    = 1'b1;
          cell_addr  = {nb_y[RW-1:0], nb_x[CW-1:0]};
          nb_col_nxt = nb_x[CW-1:0];
          nb_row_nxt = nb_y[RW-1:0];
        end else if (try_r != 2'd3) begin
          try_nxt = try_r + 2'd1;
          dir_nxt = dir_adv;
        end
      end
      mzb_pkg::S_NB_CHK: begin
        nbcell_nxt = cell_rdata;
        if (!nb_found && try_r != 2'd3) begin
          try_nxt = try_r + 2'd1;
          dir_nxt = dir_adv;
        end
      end
      mzb_pkg::S_WR_TOP: begin
        // wall between top and a right or lower neighbour sits in the top cell
        cell_v = topcell_r;
        if (dir_r == mzb_pkg::DIR_EAST) begin
          cell_v[mzb_pkg::CELL_RWALL] = 1'b0;
        end else begin
          cell_v[mzb_pkg::CELL_BWALL] = 1'b0;
        end
        cell_en    = 1'b1;
        cell_we    = 1'b1;
        cell_addr  = {top_row_r, top_col_r};
        cell_wdata = cell_v;
      end
      mzb_pkg::S_PUSH: begin
        cell_v = nbcell_r;
        if (walk_mode_r) begin
          cell_v[mzb_pkg::CELL_VIS] = 1'b1;
        end else begin
          cell_v[mzb_pkg::CELL_GEN] = 1'b1;
          if (dir_r == mzb_pkg::DIR_WEST) begin
            cell_v[mzb_pkg::CELL_RWALL] = 1'b0;
          end else if (dir_r == mzb_pkg::DIR_NORTH) begin
            cell_v[mzb_pkg::CELL_BWALL] = 1'b0;
          end
        end
        cell_en     = 1'b1;
        cell_we     = 1'b1;
        cell_addr   = {nb_row_r, nb_col_r};
        cell_wdata  = cell_v;
        stk_en      = 1'b1;
        stk_we      = 1'b1;
        stk_addr    = count_r[SAW-1:0];
        stk_wdata   = {nb_row_r, nb_col_r};
        count_nxt   = count_r + SCW'(1);
        top_col_nxt = nb_col_r;
        top_row_nxt = nb_row_r;
        moved_nxt   = 1'b1;
      end
      mzb_pkg::S_POP: begin
        cell_v                     = topcell_r;
        cell_v[mzb_pkg::CELL_DEAD] = 1'b1;
        cell_en    = walk_mode_r;
        cell_we    = walk_mode_r;
        cell_addr  = {top_row_r, top_col_r};
        cell_wdata = cell_v;
        count_nxt  = count_r - SCW'(1);
        dead_nxt   = 1'b1;
      end
      mzb_pkg::S_POP_RD: begin
        stk_en   = 1'b1;
        stk_addr = SAW'(count_r - SCW'(1));
      end
      mzb_pkg::S_POP_CAP: begin
        top_col_nxt = stk_rdata[CW-1:0];
        top_row_nxt = stk_rdata[CAW-1:CW];
      end
      mzb_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_moved_nxt = moved_r;
          out_dead_nxt  = dead_r;
          out_empty_nxt = (count_r == '0);
          out_col_nxt   = (count_r == '0) ? 6'd0 : 6'(top_col_r);
          out_row_nxt   = (count_r == '0) ? 6'd0 : 6'(top_row_r);
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mzb_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_mode_r <= 1'b0;
      cols_r      <= mzb_pkg::COLS_RESET;
      rows_r      <= mzb_pkg::ROWS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mzb_pkg::CFG_WALK_MODE: walk_mode_r <= cfg_data[0];
        mzb_pkg::CFG_COLS:      cols_r      <= cfg_data;
        mzb_pkg::CFG_ROWS:      rows_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    top_col_r   <= top_col_nxt;
    top_row_r   <= top_row_nxt;
    req_col_r   <= req_col_nxt;
    req_row_r   <= req_row_nxt;
    req_turn_r  <= req_turn_nxt;
    dir_r       <= dir_nxt;
    try_r       <= try_nxt;
    topcell_r   <= topcell_nxt;
    nbcell_r    <= nbcell_nxt;
    nb_col_r    <= nb_col_nxt;
    nb_row_r    <= nb_row_nxt;
    moved_r     <= moved_nxt;
    dead_r      <= dead_nxt;
    out_moved_r <= out_moved_nxt;
    out_dead_r  <= out_dead_nxt;
    out_col_r   <= out_col_nxt;
    out_row_r   <= out_row_nxt;
    out_empty_r <= out_empty_nxt;
  end

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign in_ready        = (state_r == mzb_pkg::S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_moved       = out_moved_r;
  assign out_dead_end    = out_dead_r;
  assign out_top_col     = out_col_r;
  assign out_top_row     = out_row_r;
  assign out_stack_empty = out_empty_r;

endmodule
